// ===== rtl/ufm_pkg.sv =====
package ufm_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_IP   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_IP     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_PORT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_PORT   = 8'd3;

    localparam int MAC_FIRST_POS   = 6;
    localparam int MAC_BYTES       = 6;
    localparam int ETYPE_HI_POS    = 12;
    localparam int ETYPE_LO_POS    = 13;
    localparam int IHL_POS         = 14;
    localparam int PROTO_POS       = 23;
    localparam int SIP_FIRST_POS   = 26;
    localparam int DIP_FIRST_POS   = 30;
    localparam int IP_END_POS      = 34;
    localparam int ETH_HDR_BYTES   = 14;
    localparam int UDP_HDR_BYTES   = 8;
    localparam int MIN_IHL_WORDS   = 5;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef enum logic [2:0] {
        STATUS_MATCH     = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_NOT_IPV4  = 3'd2,
        STATUS_NOT_UDP   = 3'd3,
        STATUS_MISMATCH  = 3'd4,
        STATUS_BAD_IHL   = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } match_cfg_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [15:0] ethertype;
        logic [3:0]  header_words;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } frame_fields_t;

endpackage

// ===== rtl/ufm_config.sv =====
module ufm_config
    import ufm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output match_cfg_t             match_cfg
);

    match_cfg_t cfg_reg;
    match_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE_IP:   cfg_next.source_ip   = cfg_data;
                CFG_DEST_IP:     cfg_next.dest_ip     = cfg_data;
                CFG_SOURCE_PORT: cfg_next.source_port = cfg_data[15:0];
                CFG_DEST_PORT:   cfg_next.dest_port   = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign match_cfg = cfg_reg;

endmodule

// ===== rtl/ufm_capture.sv =====
module ufm_capture
    import ufm_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       frame_byte,
    input  logic             final_byte,
    output frame_fields_t    fields_upd,
    output logic [POS_W-1:0] length_upd
);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    frame_fields_t    fields_reg;
    frame_fields_t    fields_next;
    frame_fields_t    upd;
    logic [POS_W-1:0] udp_pos;
    logic             in_range;

    assign udp_pos  = POS_W'(ETH_HDR_BYTES) + POS_W'({fields_reg.header_words, 2'b00});
    assign in_range = (pos_reg < POS_LIMIT);

    always_comb
    begin
        upd = fields_reg;
        if (in_range)
        begin
            for (int i = 0; i < MAC_BYTES; i++)
            begin
                if (pos_reg == POS_W'(MAC_FIRST_POS + i))
                begin
                    upd.mac[8*(MAC_BYTES-1-i) +: 8] = frame_byte;
                end
            end
            if (pos_reg == POS_W'(ETYPE_HI_POS) || pos_reg == POS_W'(ETYPE_LO_POS))
            begin
                upd.ethertype = {fields_reg.ethertype[7:0], frame_byte};
            end
            if (pos_reg == POS_W'(IHL_POS))
            begin
                upd.header_words = frame_byte[3:0];
            end
            if (pos_reg == POS_W'(PROTO_POS))
            begin
                upd.protocol = frame_byte;
            end
            if (pos_reg >= POS_W'(SIP_FIRST_POS) && pos_reg < POS_W'(DIP_FIRST_POS))
            begin
                upd.source_ip = {fields_reg.source_ip[23:0], frame_byte};
            end
            if (pos_reg >= POS_W'(DIP_FIRST_POS) && pos_reg < POS_W'(IP_END_POS))
            begin
                upd.dest_ip = {fields_reg.dest_ip[23:0], frame_byte};
            end
            if (pos_reg > POS_W'(IHL_POS))
            begin
                if (pos_reg == udp_pos || pos_reg == udp_pos + POS_W'(1))
                begin
                    upd.source_port = {fields_reg.source_port[7:0], frame_byte};
                end
                else if (pos_reg == udp_pos + POS_W'(2) || pos_reg == udp_pos + POS_W'(3))
                begin
                    upd.dest_port = {fields_reg.dest_port[7:0], frame_byte};
                end
            end
        end
    end

    assign length_upd = in_range ? pos_reg + POS_W'(1) : pos_reg;
    assign fields_upd = upd;

    always_comb
    begin
        pos_next    = pos_reg;
        fields_next = fields_reg;
        if (byte_valid)
        begin
            if (final_byte)
            begin
                pos_next    = '0;
                fields_next = '0;
            end
            else
            begin
                pos_next    = length_upd;
                fields_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fields_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            fields_reg <= fields_next;
        end
    end

endmodule

// ===== rtl/ufm_classify.sv =====
module ufm_classify
    import ufm_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  frame_fields_t    fields,
    input  logic [POS_W-1:0] frame_length,
    input  match_cfg_t       match_cfg,
    output status_t          status
);

    logic [POS_W-1:0] udp_end;

    assign udp_end = POS_W'(ETH_HDR_BYTES + UDP_HDR_BYTES)
                   + POS_W'({fields.header_words, 2'b00});

    always_comb
    begin
        if (frame_length < POS_W'(IP_END_POS))
        begin
            status = STATUS_SHORT;
        end
        else if (fields.ethertype != ETHERTYPE_IPV4)
        begin
            status = STATUS_NOT_IPV4;
        end
        else if (fields.protocol != PROTO_UDP)
        begin
            status = STATUS_NOT_UDP;
        end
        else if (fields.header_words < 4'(MIN_IHL_WORDS))
        begin
            status = STATUS_BAD_IHL;
        end
        else if (frame_length < udp_end)
        begin
            status = STATUS_SHORT;
        end
        else if (fields.source_ip != match_cfg.source_ip
              || fields.dest_ip != match_cfg.dest_ip
              || fields.source_port != match_cfg.source_port
              || fields.dest_port != match_cfg.dest_port)
        begin
            status = STATUS_MISMATCH;
        end
        else
        begin
            status = STATUS_MATCH;
        end
    end

endmodule

// ===== rtl/udp_flow_frame_matcher.sv =====
// Ethernet/IPv4/UDP flow filter. Frame bytes enter on the s_axis channel in
// wire order, one item per byte, with tlast set on the last byte of a frame.
// For every frame the block returns one item on the m_axis channel holding a
// status code and the source MAC address of the frame.
// The cfg channel writes the match registers: index 0 source IP, 1 destination
// IP, 2 source port, 3 destination port. Other indexes are ignored, and cfg_ready
// is always high. Registers should be written only while no frame is in flight.
// A byte is accepted every cycle while s_axis_tready is high. The result for a
// frame is presented in the cycle after its last byte is accepted, from a single
// output register.
// When the receiver stalls, the output register holds its item and
// s_axis_tready falls until the item is taken, so bytes are never dropped.
// Reset clears the match registers, the frame capture state and the output
// register. Bytes beyond MAX_FRAME_BYTES in a frame are not counted or captured.
module udp_flow_frame_matcher
    import ufm_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] frame_byte
    input  logic                   s_axis_tlast,   // final_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [55:0]            m_axis_tdata,   // [2:0] match_status, [50:3] sender_mac
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    match_cfg_t       match_cfg;
    frame_fields_t    fields_upd;
    logic [POS_W-1:0] length_upd;
    status_t          status;
    logic             in_accept;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    logic [47:0]      out_mac_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ufm_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .match_cfg (match_cfg)
    );

    ufm_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_accept),
        .frame_byte (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .fields_upd (fields_upd),
        .length_upd (length_upd)
    );

    ufm_classify #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_classify (
        .fields       (fields_upd),
        .frame_length (length_upd),
        .match_cfg    (match_cfg),
        .status       (status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept && s_axis_tlast)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_status_reg <= STATUS_MATCH;
            out_mac_reg    <= '0;
        end
        else if (in_accept && s_axis_tlast)
        begin
            out_status_reg <= status;
            out_mac_reg    <= fields_upd.mac;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_mac_reg, out_status_reg};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ufm_pkg::*;

    localparam int FRAME_LIMIT    = 96;
    localparam int IP_MIN_BYTES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

    localparam logic [31:0] SIP_A   = 32'hC0A8_0001;
    localparam logic [31:0] DIP_A   = 32'h0A00_00FE;
    localparam logic [15:0] SPORT_A = 16'h1F90;
    localparam logic [15:0] DPORT_A = 16'hD431;
    localparam logic [47:0] MAC_A   = 48'h0200_0000_0001;

    typedef struct packed {
        status_t     status;
        logic [47:0] mac;
    } verdict_t;

    typedef struct packed {
        logic [31:0] pos;
        logic [47:0] mac;
        logic [15:0] etype;
        logic [3:0]  hwords;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } capture_t;

    typedef struct {
        int          len;
        logic [47:0] mac;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        typed;
        verdict_t    want;
    } frame_desc_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [55:0]            m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [31:0] flow_sip = '0;
    logic [31:0] flow_dip = '0;
    logic [15:0] flow_sport = '0;
    logic [15:0] flow_dport = '0;
    capture_t    cap = '0;

    verdict_t    pending_verdicts[$];
    frame_desc_t directed_frames[$];
    int          error_count = 0;
    int          stall_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    udp_flow_frame_matcher #(
        .MAX_FRAME_BYTES (FRAME_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic status_t frame_verdict(input logic [31:0] len);
        if (len < ETH_HDR_BYTES + IP_MIN_BYTES)
            return STATUS_SHORT;
        if (cap.etype != ETHERTYPE_IPV4)
            return STATUS_NOT_IPV4;
        if (cap.proto != PROTO_UDP)
            return STATUS_NOT_UDP;
        if (cap.hwords < MIN_IHL_WORDS)
            return STATUS_BAD_IHL;
        if (len < ETH_HDR_BYTES + 4 * cap.hwords + UDP_HDR_BYTES)
            return STATUS_SHORT;
        if (cap.sip != flow_sip || cap.dip != flow_dip ||
            cap.sport != flow_sport || cap.dport != flow_dport)
            return STATUS_MISMATCH;
        return STATUS_MATCH;
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic last,
                                       output logic done, output verdict_t v);
        int p;
        int udp;
        done = 1'b0;
        v = '0;
        if (cap.pos < FRAME_LIMIT)
        begin
            p = int'(cap.pos);
            if (p >= MAC_FIRST_POS && p < MAC_FIRST_POS + MAC_BYTES)
                cap.mac[8 * (MAC_FIRST_POS + MAC_BYTES - 1 - p) +: 8] = b;
            else if (p == ETYPE_HI_POS || p == ETYPE_LO_POS)
                cap.etype = {cap.etype[7:0], b};
            else if (p == IHL_POS)
                cap.hwords = b[3:0];
            else if (p == PROTO_POS)
                cap.proto = b;
            else if (p >= SIP_FIRST_POS && p < DIP_FIRST_POS)
                cap.sip = {cap.sip[23:0], b};
            else if (p >= DIP_FIRST_POS && p < IP_END_POS)
                cap.dip = {cap.dip[23:0], b};
            if (p > IHL_POS)
            begin
                udp = ETH_HDR_BYTES + 4 * int'(cap.hwords);
                if (p == udp || p == udp + 1)
                    cap.sport = {cap.sport[7:0], b};
                else if (p == udp + 2 || p == udp + 3)
                    cap.dport = {cap.dport[7:0], b};
            end
            cap.pos = cap.pos + 1;
        end
        if (last)
        begin
            done = 1'b1;
            v.status = frame_verdict(cap.pos);
            v.mac = cap.mac;
            cap = '0;
        end
    endfunction

    function automatic logic [7:0] frame_byte_at(input frame_desc_t d, input int p);
        logic [7:0] b;
        int udp;
        b = 8'($urandom);
        udp = ETH_HDR_BYTES + 4 * int'(d.ver_ihl[3:0]);
        if (p >= MAC_FIRST_POS && p < MAC_FIRST_POS + MAC_BYTES)
            b = d.mac[8 * (MAC_FIRST_POS + MAC_BYTES - 1 - p) +: 8];
        else if (p == ETYPE_HI_POS)
            b = d.etype[15:8];
        else if (p == ETYPE_LO_POS)
            b = d.etype[7:0];
        else if (p == IHL_POS)
            b = d.ver_ihl;
        else if (p == PROTO_POS)
            b = d.proto;
        else if (p >= SIP_FIRST_POS && p < DIP_FIRST_POS)
            b = d.sip[8 * (DIP_FIRST_POS - 1 - p) +: 8];
        else if (p >= DIP_FIRST_POS && p < IP_END_POS)
            b = d.dip[8 * (IP_END_POS - 1 - p) +: 8];
        if (p > IHL_POS && p >= udp && p < udp + 2)
            b = d.sport[8 * (udp + 1 - p) +: 8];
        else if (p > IHL_POS && p >= udp + 2 && p < udp + 4)
            b = d.dport[8 * (udp + 3 - p) +: 8];
        return b;
    endfunction

    function automatic frame_desc_t row(input int len, input logic [47:0] mac,
                                        input logic [15:0] etype, input logic [7:0] ver_ihl,
                                        input logic [7:0] proto, input logic [31:0] sip,
                                        input logic [31:0] dip, input logic [15:0] sport,
                                        input logic [15:0] dport, input logic typed,
                                        input status_t status);
        frame_desc_t d;
        d.len = len;
        d.mac = mac;
        d.etype = etype;
        d.ver_ihl = ver_ihl;
        d.proto = proto;
        d.sip = sip;
        d.dip = dip;
        d.sport = sport;
        d.dport = dport;
        d.typed = typed;
        d.want.status = status;
        d.want.mac = (len >= MAC_FIRST_POS + MAC_BYTES) ? mac : 48'h0;
        return d;
    endfunction

    function automatic void add_row(input frame_desc_t d);
        directed_frames.insert(directed_frames.size(), d);
    endfunction

    function automatic logic [31:0] perturb(input logic [31:0] v, input int width);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            return v;
        if (pick < 94)
            return v ^ (32'd1 << $urandom_range(0, width - 1));
        return $urandom;
    endfunction

    function automatic frame_desc_t random_frame();
        frame_desc_t d;
        int ihl;
        int udp_end;
        int pick;
        d.typed = 1'b0;
        d.want = '0;
        d.mac = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 99) < 10)
        begin
            d.len = $urandom_range(1, 64);
            d.etype = 16'($urandom);
            d.ver_ihl = 8'($urandom);
            d.proto = 8'($urandom);
            d.sip = $urandom;
            d.dip = $urandom;
            d.sport = 16'($urandom);
            d.dport = 16'($urandom);
            return d;
        end
        d.etype = ($urandom_range(0, 99) < 92) ? ETHERTYPE_IPV4 : 16'($urandom);
        pick = $urandom_range(0, 99);
        ihl = (pick < 80) ? 5 : (pick < 95) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        d.ver_ihl[3:0] = 4'(ihl);
        d.ver_ihl[7:4] = ($urandom_range(0, 99) < 90) ? 4'd4 : 4'($urandom);
        d.proto = ($urandom_range(0, 99) < 92) ? PROTO_UDP : 8'($urandom);
        d.sip = perturb(flow_sip, 32);
        d.dip = perturb(flow_dip, 32);
        d.sport = 16'(perturb({16'h0, flow_sport}, 16));
        d.dport = 16'(perturb({16'h0, flow_dport}, 16));
        udp_end = ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            d.len = udp_end + $urandom_range(0, 20);
        else if (pick < 93)
            d.len = $urandom_range(1, udp_end);
        else
            d.len = $urandom_range(udp_end, 200);
        return d;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input verdict_t typed_want);
        logic     done;
        verdict_t v;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        s_axis_tlast = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_byte(b, last, done, v);
        if (done)
            pending_verdicts.insert(pending_verdicts.size(), typed ? typed_want : v);
    endtask

    task automatic send_frame(input frame_desc_t d);
        for (int p = 0; p < d.len; p++)
            send_byte(frame_byte_at(d, p), p == d.len - 1, d.typed, d.want);
    endtask

    task automatic wait_verdicts_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_match_reg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SOURCE_IP:   flow_sip = value;
            CFG_DEST_IP:     flow_dip = value;
            CFG_SOURCE_PORT: flow_sport = value[15:0];
            CFG_DEST_PORT:   flow_dport = value[15:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_matcher(input logic [31:0] sip, input logic [31:0] dip,
                                   input logic [31:0] sport_word,
                                   input logic [31:0] dport_word);
        write_match_reg(CFG_SOURCE_IP, sip);
        write_match_reg(CFG_DEST_IP, dip);
        write_match_reg(CFG_SOURCE_PORT, sport_word);
        write_match_reg(CFG_DEST_PORT, dport_word);
        write_match_reg(($urandom_range(0, 1) == 0) ? CFG_UNUSED_LOW : CFG_UNUSED_HIGH,
                        $urandom);
    endtask

    task automatic run_random_frames(input int byte_goal, input int frame_goal);
        int          byte_count;
        int          frame_count;
        frame_desc_t d;
        byte_count = 0;
        frame_count = 0;
        while (byte_count < byte_goal || frame_count < frame_goal)
        begin
            d = random_frame();
            send_frame(d);
            byte_count += d.len;
            frame_count++;
        end
    endtask

    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result item arrived with no frame outstanding");
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                begin
                    $error("match_status: expected %0d, actual %0d",
                           want.status, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[50:3] !== want.mac)
                begin
                    $error("sender_mac: expected %h, actual %h", want.mac, m_axis_tdata[50:3]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_MATCH));
        add_row(row(1, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(8, 48'hA1B2_C3D4_E5F6, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b0, STATUS_SHORT));
        add_row(row(20, MAC_A, 16'h86DD, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(33, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(34, MAC_A, 16'h86DD, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_NOT_IPV4));
        add_row(row(60, 48'h0, 16'h0000, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_NOT_IPV4));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, 8'd6,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_NOT_UDP));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, 8'hFF,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_NOT_UDP));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h40, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_BAD_IHL));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h44, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_BAD_IHL));
        add_row(row(34, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(41, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(46, MAC_A, ETHERTYPE_IPV4, 8'h46, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_MATCH));
        add_row(row(82, MAC_A, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_MATCH));
        add_row(row(81, MAC_A, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_SHORT));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'hF5, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b1, STATUS_MATCH));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A ^ 32'h1, DIP_A, SPORT_A, DPORT_A,
                    1'b1, STATUS_MISMATCH));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A ^ 32'h8000_0000, SPORT_A, DPORT_A,
                    1'b1, STATUS_MISMATCH));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A ^ 16'h1, DPORT_A,
                    1'b1, STATUS_MISMATCH));
        add_row(row(42, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A ^ 16'h8000,
                    1'b1, STATUS_MISMATCH));
        add_row(row(FRAME_LIMIT, MAC_A, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                    SIP_A, DIP_A, SPORT_A, DPORT_A, 1'b0, STATUS_MATCH));
        add_row(row(FRAME_LIMIT + 52, MAC_A, ETHERTYPE_IPV4, 8'h45,
                    PROTO_UDP, SIP_A, DIP_A, SPORT_A, DPORT_A,
                    1'b1, STATUS_MATCH));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 17;
        sink_idle_pct = 81;
        // All match registers are zero after reset.
        send_frame(row(42, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                       32'h0, 32'h0, 16'h0, 16'h0, 1'b1, STATUS_MATCH));
        wait_verdicts_drained();

        program_matcher(SIP_A, DIP_A, {16'hFFFF, SPORT_A}, {16'h5A5A, DPORT_A});
        write_match_reg(CFG_UNUSED_LOW, 32'hFFFF_FFFF);
        write_match_reg(CFG_UNUSED_HIGH, 32'h0);
        foreach (directed_frames[i])
            send_frame(directed_frames[i]);
        wait_verdicts_drained();

        program_matcher($urandom, $urandom, $urandom, $urandom);
        run_random_frames(260, 4);
        wait_verdicts_drained();

        src_idle_pct = 81;
        sink_idle_pct = 17;
        program_matcher(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random_frames(260, 4);
        wait_verdicts_drained();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        program_matcher($urandom, $urandom, $urandom, $urandom);
        run_random_frames(260, 4);
        wait_verdicts_drained();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== udp_flow_frame_matcher.f =====
rtl/ufm_pkg.sv
rtl/ufm_config.sv
rtl/ufm_capture.sv
rtl/ufm_classify.sv
rtl/udp_flow_frame_matcher.sv
test/testbench.sv
